// ===== rtl/cdpu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdpu_pkg
// Shared types and constants of the conditional data-processing unit.
// ----------------------------------------------------------------------------
package cdpu_pkg;
    localparam logic [7:0] RsByteMask = 8'hFF;
    localparam logic [3:0] CondNv = 4'hF;
    localparam logic [3:0] RegLr = 4'd14;
    localparam logic [3:0] RegPc = 4'd15;

    localparam logic [3:0] OpAnd = 4'd0;
    localparam logic [3:0] OpEor = 4'd1;
    localparam logic [3:0] OpSub = 4'd2;
    localparam logic [3:0] OpRsb = 4'd3;
    localparam logic [3:0] OpAdd = 4'd4;
    localparam logic [3:0] OpAdc = 4'd5;
    localparam logic [3:0] OpSbc = 4'd6;
    localparam logic [3:0] OpRsc = 4'd7;
    localparam logic [3:0] OpTst = 4'd8;
    localparam logic [3:0] OpTeq = 4'd9;
    localparam logic [3:0] OpCmp = 4'd10;
    localparam logic [3:0] OpCmn = 4'd11;
    localparam logic [3:0] OpOrr = 4'd12;
    localparam logic [3:0] OpMov = 4'd13;
    localparam logic [3:0] OpBic = 4'd14;
    localparam logic [3:0] OpMvn = 4'd15;

    typedef struct packed {
        logic [3:0]  cond;
        logic        dp;
        logic [31:0] word;
    } dec_t;
endpackage
`default_nettype wire

// ===== rtl/cdpu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdpu_front
// Input register stage: accept a word and classify it as data processing.
// ----------------------------------------------------------------------------
module cdpu_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [31:0]     instruction_word,
    output logic                 dq_valid,
    input  wire logic            dq_ready,
    output cdpu_pkg::dec_t       dq_data
);
    import cdpu_pkg::*;

    logic valid_reg;
    dec_t data_reg;
    logic dp;

    always_comb
    begin
        dp = 1'b1;
        if (instruction_word[27:26] != 2'b00)
            dp = 1'b0;
        if ((instruction_word & 32'h0FFFFFF0) == 32'h012FFF10)
            dp = 1'b0;
        if (!instruction_word[25] && instruction_word[7] && instruction_word[4])
            dp = 1'b0;
    end

    assign in_ready = !valid_reg || dq_ready;
    assign dq_valid = valid_reg;
    assign dq_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg.cond <= instruction_word[31:28];
            data_reg.dp   <= dp;
            data_reg.word <= instruction_word;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cdpu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdpu_queue
// Two-entry queue between the decode and execute parts.
// ----------------------------------------------------------------------------
module cdpu_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  cdpu_pkg::dec_t       s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output cdpu_pkg::dec_t       m_data
);
    import cdpu_pkg::*;

    dec_t mem_reg [2];
    logic rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign s_ready = cnt_reg != 2'd2;
    assign m_valid = cnt_reg != 2'd0;
    assign m_data  = mem_reg[rd_ptr_reg];
    assign push = s_valid && s_ready;
    assign pop  = m_valid && m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= s_data;
    end
endmodule
`default_nettype wire

// ===== rtl/cdpu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdpu_back
// Execute part: condition check, shifter, ALU, register file and flags.
// ----------------------------------------------------------------------------
module cdpu_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            dq_valid,
    output logic                 dq_ready,
    input  cdpu_pkg::dec_t       dq_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 executed,
    output logic                 wrote_register,
    output logic [3:0]           dest_index,
    output logic [31:0]          result_value,
    output logic [3:0]           flags_after
);
    import cdpu_pkg::*;

    logic [31:0] rf_reg [16];
    logic [3:0]  flags_reg;
    logic        ov_reg;
    logic        ex_reg, wr_reg;
    logic [3:0]  rd_reg;
    logic [31:0] res_reg;

    logic [31:0] w;
    logic fn, fz, fc, fv, pass, exec, wr, sc, ca, va, arith, setf;
    logic [31:0] a, b, vm, r, opx, opy;
    logic [7:0]  amt;
    logic [4:0]  rot;
    logic [1:0]  st;
    logic        cin;
    logic [32:0] sum;
    logic [3:0]  fnew;
    logic [63:0] dbl;
    logic        fire;

    assign w = dq_data.word;
    assign {fn, fz, fc, fv} = flags_reg;
    assign fire = dq_valid && dq_ready;
    assign dq_ready = !ov_reg || out_ready;

    always_comb
    begin
        unique case (dq_data.cond)
            4'd0:  pass = fz;
            4'd1:  pass = !fz;
            4'd2:  pass = fc;
            4'd3:  pass = !fc;
            4'd4:  pass = fn;
            4'd5:  pass = !fn;
            4'd6:  pass = fv;
            4'd7:  pass = !fv;
            4'd8:  pass = fc && !fz;
            4'd9:  pass = !fc || fz;
            4'd10: pass = fn == fv;
            4'd11: pass = fn != fv;
            4'd12: pass = !fz && (fn == fv);
            4'd13: pass = fz || (fn != fv);
            4'd14: pass = 1'b1;
            CondNv: pass = 1'b0;
        endcase
    end

    always_comb
    begin
        a   = rf_reg[w[19:16]];
        vm  = rf_reg[w[3:0]];
        st  = w[6:5];
        b   = vm;
        sc  = fc;
        rot = 5'd0;
        amt = 8'd0;
        dbl = 64'd0;
        if (w[25])
        begin
            rot = {w[11:8], 1'b0};
            dbl = {24'd0, w[7:0], 24'd0, w[7:0]} >> rot;
            b   = dbl[31:0];
            sc  = (rot == 5'd0) ? fc : b[31];
        end
        else
        begin
            if (w[4])
                amt = rf_reg[w[11:8]][7:0] & RsByteMask;
            else
                amt = {3'd0, w[11:7]};
            if (!w[4] && amt == 8'd0)
            begin
                unique case (st)
                    2'd0: begin b = vm; sc = fc; end
                    2'd1: begin b = 32'd0; sc = vm[31]; end
                    2'd2: begin b = {32{vm[31]}}; sc = vm[31]; end
                    default: begin b = {fc, vm[31:1]}; sc = vm[0]; end
                endcase
            end
            else if (amt != 8'd0)
            begin
                unique case (st)
                    2'd0:
                    begin
                        dbl = {32'd0, vm} << amt[5:0];
                        if (amt < 8'd32) begin b = dbl[31:0]; sc = dbl[32]; end
                        else begin b = 32'd0; sc = (amt == 8'd32) ? vm[0] : 1'b0; end
                    end
                    2'd1:
                    begin
                        dbl = {vm, 32'd0} >> amt[4:0];
                        if (amt < 8'd32) begin b = dbl[63:32]; sc = dbl[31]; end
                        else begin b = 32'd0; sc = (amt == 8'd32) ? vm[31] : 1'b0; end
                    end
                    2'd2:
                    begin
                        dbl = 64'({{32{vm[31]}}, vm, 32'd0} >> amt[4:0]);
                        if (amt < 8'd32) begin b = dbl[63:32]; sc = dbl[31]; end
                        else begin b = {32{vm[31]}}; sc = vm[31]; end
                    end
                    default:
                    begin
                        dbl = {vm, vm} >> amt[4:0];
                        b   = dbl[31:0];
                        sc  = b[31];
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        arith = 1'b1;
        wr    = 1'b1;
        opx   = a;
        opy   = b;
        cin   = 1'b0;
        unique case (w[24:21])
            OpSub, OpCmp: begin opy = ~b; cin = 1'b1; end
            OpRsb:        begin opx = b; opy = ~a; cin = 1'b1; end
            OpAdc:        cin = fc;
            OpSbc:        begin opy = ~b; cin = fc; end
            OpRsc:        begin opx = b; opy = ~a; cin = fc; end
            default:      ;
        endcase
        sum = {1'b0, opx} + {1'b0, opy} + {32'd0, cin};
        ca  = sum[32];
        va  = (~(opx[31] ^ opy[31])) & (opx[31] ^ sum[31]);
        r   = sum[31:0];
        unique case (w[24:21])
            OpAnd: begin r = a & b;  arith = 1'b0; end
            OpEor: begin r = a ^ b;  arith = 1'b0; end
            OpTst: begin r = a & b;  arith = 1'b0; wr = 1'b0; end
            OpTeq: begin r = a ^ b;  arith = 1'b0; wr = 1'b0; end
            OpCmp, OpCmn: wr = 1'b0;
            OpOrr: begin r = a | b;  arith = 1'b0; end
            OpMov: begin r = b;      arith = 1'b0; end
            OpBic: begin r = a & ~b; arith = 1'b0; end
            OpMvn: begin r = ~b;     arith = 1'b0; end
            default: ;
        endcase
        exec = pass && dq_data.dp;
        setf = exec && w[20] && (w[15:12] != RegPc);
        fnew = {r[31], r == 32'd0, arith ? ca : sc, arith ? va : fv};
    end

    assign out_valid      = ov_reg;
    assign executed       = ex_reg;
    assign wrote_register = wr_reg;
    assign dest_index     = rd_reg;
    assign result_value   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg    <= 1'b0;
            flags_reg <= 4'd0;
            for (int i = 0; i < 16; i++)
                rf_reg[i] <= (4'(i) == RegLr) ? 32'hFFFFFFFF : 32'd0;
        end
        else
        begin
            if (dq_ready)
                ov_reg <= dq_valid;
            if (fire && setf)
                flags_reg <= fnew;
            if (fire && exec && wr)
                rf_reg[w[15:12]] <= r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ex_reg      <= exec;
            wr_reg      <= exec && wr;
            rd_reg      <= w[15:12];
            res_reg     <= exec ? r : 32'd0;
            flags_after <= setf ? fnew : flags_reg;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/conditional_data_processing_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conditional_data_processing_unit
// Conditional data-processing execute block with register file and flags.
//
// The input channel (in_valid/in_ready) takes one instruction word per
// transaction; the output channel (out_valid/out_ready) returns one result
// per word: executed, wrote_register, dest_index, result_value, flags_after.
// A front register decodes the word, a two-entry queue decouples it from
// the execute stage, which tests the condition, shifts, runs the ALU and
// updates registers and flags as it loads its output register.
// A word passes the front register, the queue and the output register in
// turn; throughput is one word per cycle while out_ready is high, set by the
// combinational shifter and adder loop through the register file and flags.
// Reset clears all registers and the flags, except register 14 (all ones).
// When the receiver stalls, the output register holds, the queue fills,
// then in_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module conditional_data_processing_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] instruction_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             executed,
    output logic             wrote_register,
    output logic [3:0]       dest_index,
    output logic [31:0]      result_value,
    output logic [3:0]       flags_after
);
    import cdpu_pkg::*;

    logic f_valid, f_ready, q_valid, q_ready;
    dec_t f_data, q_data;

    cdpu_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .instruction_word(instruction_word),
        .dq_valid(f_valid), .dq_ready(f_ready), .dq_data(f_data)
    );

    cdpu_queue u_queue (
        .clk(clk), .rst_n(rst_n), .s_valid(f_valid), .s_ready(f_ready),
        .s_data(f_data), .m_valid(q_valid), .m_ready(q_ready), .m_data(q_data)
    );

    cdpu_back u_back (
        .clk(clk), .rst_n(rst_n), .dq_valid(q_valid), .dq_ready(q_ready),
        .dq_data(q_data), .out_valid(out_valid), .out_ready(out_ready),
        .executed(executed), .wrote_register(wrote_register),
        .dest_index(dest_index), .result_value(result_value),
        .flags_after(flags_after)
    );
endmodule
`default_nettype wire

// ===== tb/conditional_data_processing_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conditional_data_processing_unit_checker
// Watches both channels of the execute block, keeps a shadow register file
// and flag set, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module conditional_data_processing_unit_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [31:0] instruction_word,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        executed,
    input  wire logic        wrote_register,
    input  wire logic [3:0]  dest_index,
    input  wire logic [31:0] result_value,
    input  wire logic [3:0]  flags_after,
    output int               fail_count,
    output int               pending
);
    import cdpu_pkg::*;

    typedef struct packed {
        logic        exec;
        logic        wr;
        logic [3:0]  rd;
        logic [31:0] val;
        logic [3:0]  flg;
    } alu_result_t;

    logic [31:0] shadow_regs [16];
    logic        fn, fz, fc, fv;
    alu_result_t expected_results [$];

    assign pending = expected_results.size();

    function automatic logic cond_passes(input logic [3:0] cc);
        case (cc)
            4'd0: return fz;
            4'd1: return !fz;
            4'd2: return fc;
            4'd3: return !fc;
            4'd4: return fn;
            4'd5: return !fn;
            4'd6: return fv;
            4'd7: return !fv;
            4'd8: return fc && !fz;
            4'd9: return !fc || fz;
            4'd10: return fn == fv;
            4'd11: return fn != fv;
            4'd12: return !fz && (fn == fv);
            4'd13: return fz || (fn != fv);
            4'd14: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        n = n % 32;
        if (n == 0) return x;
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] operand2(input logic [31:0] w, output logic co);
        logic [31:0] v;
        int          amt;
        logic [1:0]  kind;
        logic [31:0] r;
        if (w[25]) begin
            amt = int'(w[11:8]) * 2;
            r = ror32({24'd0, w[7:0]}, amt);
            co = (amt == 0) ? fc : r[31];
            return r;
        end
        v = shadow_regs[w[3:0]];
        kind = w[6:5];
        if (!w[4]) begin
            amt = int'(w[11:7]);
            if (amt == 0) begin
                case (kind)
                    2'd0: begin co = fc; return v; end
                    2'd1: begin co = v[31]; return 32'd0; end
                    2'd2: begin co = v[31]; return {32{v[31]}}; end
                    default: begin co = v[0]; return {fc, v[31:1]}; end
                endcase
            end
        end else begin
            amt = int'(shadow_regs[w[11:8]] & {24'd0, RsByteMask});
            if (amt == 0) begin co = fc; return v; end
        end
        case (kind)
            2'd0: begin
                if (amt < 32) begin co = v[32 - amt]; return v << amt; end
                co = (amt == 32) ? v[0] : 1'b0;
                return 32'd0;
            end
            2'd1: begin
                if (amt < 32) begin co = v[amt - 1]; return v >> amt; end
                co = (amt == 32) ? v[31] : 1'b0;
                return 32'd0;
            end
            2'd2: begin
                if (amt < 32) begin co = v[amt - 1]; return $signed(v) >>> amt; end
                co = v[31];
                return {32{v[31]}};
            end
            default: begin
                if (amt % 32 == 0) begin co = v[31]; return v; end
                r = ror32(v, amt);
                co = r[31];
                return r;
            end
        endcase
    endfunction

    function automatic logic [31:0] add_carry(input logic [31:0] a, input logic [31:0] b,
                                              input logic ci, output logic co,
                                              output logic ov);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b} + {32'd0, ci};
        co = s[32];
        ov = (~(a[31] ^ b[31])) & (a[31] ^ s[31]);
        return s[31:0];
    endfunction

    function automatic alu_result_t execute_word(input logic [31:0] w);
        alu_result_t res;
        logic [31:0] a, b, r;
        logic        sc, c, v, arith, wr, dp;
        c = 1'b0; v = 1'b0; arith = 1'b1; wr = 1'b1; r = 32'd0; sc = 1'b0;
        dp = (w[27:26] == 2'b00) && ((w & 32'h0FFFFFF0) != 32'h012FFF10)
             && !(!w[25] && w[7] && w[4]);
        res.exec = 1'b0;
        if (cond_passes(w[31:28]) && dp) begin
            res.exec = 1'b1;
            a = shadow_regs[w[19:16]];
            b = operand2(w, sc);
            case (w[24:21])
                OpAnd: begin r = a & b; arith = 1'b0; end
                OpEor: begin r = a ^ b; arith = 1'b0; end
                OpSub: r = add_carry(a, ~b, 1'b1, c, v);
                OpRsb: r = add_carry(b, ~a, 1'b1, c, v);
                OpAdd: r = add_carry(a, b, 1'b0, c, v);
                OpAdc: r = add_carry(a, b, fc, c, v);
                OpSbc: r = add_carry(a, ~b, fc, c, v);
                OpRsc: r = add_carry(b, ~a, fc, c, v);
                OpTst: begin r = a & b; arith = 1'b0; wr = 1'b0; end
                OpTeq: begin r = a ^ b; arith = 1'b0; wr = 1'b0; end
                OpCmp: begin r = add_carry(a, ~b, 1'b1, c, v); wr = 1'b0; end
                OpCmn: begin r = add_carry(a, b, 1'b0, c, v); wr = 1'b0; end
                OpOrr: begin r = a | b; arith = 1'b0; end
                OpMov: begin r = b; arith = 1'b0; end
                OpBic: begin r = a & ~b; arith = 1'b0; end
                default: begin r = ~b; arith = 1'b0; end
            endcase
            if (w[20] && w[15:12] != RegPc) begin
                fn = r[31];
                fz = (r == 32'd0);
                fc = arith ? c : sc;
                if (arith) fv = v;
            end
            if (wr) shadow_regs[w[15:12]] = r;
        end else begin
            wr = 1'b0;
        end
        res.wr = wr;
        res.rd = w[15:12];
        res.val = r;
        res.flg = {fn, fz, fc, fv};
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        alu_result_t got, want;
        if (!rst_n) begin
            for (int i = 0; i < 16; i++) shadow_regs[i] = 32'd0;
            shadow_regs[RegLr] = 32'hFFFFFFFF;
            {fn, fz, fc, fv} = 4'd0;
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (in_valid && in_ready)
                expected_results.push_back(execute_word(instruction_word));
            if (out_valid && out_ready) begin
                got = '{executed, wrote_register, dest_index, result_value, flags_after};
                if (expected_results.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display({"mismatch: exp exec=%b wr=%b rd=%0d val=%h flg=%h,",
                                      " got exec=%b wr=%b rd=%0d val=%h flg=%h"},
                                     want.exec, want.wr, want.rd, want.val, want.flg,
                                     got.exec, got.wr, got.rd, got.val, got.flg);
                    end
                end
            end
        end
    end
endmodule

// ===== tb/conditional_data_processing_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conditional_data_processing_unit_test
// Drives instruction words into the execute block under varying idle
// patterns on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module conditional_data_processing_unit_test;
    import cdpu_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] instruction_word = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        executed, wrote_register;
    logic [3:0]  dest_index, flags_after;
    logic [31:0] result_value;
    int          fail_count, pending;
    int          send_idle = 0, recv_idle = 0;
    longint      cycle_count = 0;

    always #6 clk = ~clk;

    conditional_data_processing_unit uut (.*);
    conditional_data_processing_unit_checker checker_i (.*);

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_word(input logic [31:0] w);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        instruction_word <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] make_dp(input logic [3:0] cc, input logic imm,
                                            input logic [3:0] op, input logic s,
                                            input logic [3:0] rn, input logic [3:0] rd,
                                            input logic [11:0] op2);
        return {cc, 2'b00, imm, op, s, rn, rd, op2};
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        logic [11:0] op2;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 10) return $urandom;
        op2 = $urandom;
        if (!op2[11] && $urandom_range(1)) op2[7] = 1'b0;
        w = make_dp(($urandom_range(9) == 0) ? 4'hE : 4'($urandom), 1'($urandom),
                    4'($urandom), 1'($urandom), 4'($urandom_range(15)),
                    ($urandom_range(7) == 0) ? 4'd15 : 4'($urandom_range(14)), op2);
        if (pick < 20) w[31:28] = 4'hE;
        if (pick < 25) w = {w[31:28], 28'h12FFF10} | {28'd0, 4'($urandom)};
        return w;
    endfunction

    task automatic load_values();
        for (int r = 0; r < 15; r++)
            send_word(make_dp(4'hE, 1'b1, OpMov, 1'b0, 4'd0, 4'(r),
                              {4'($urandom), 8'($urandom)}));
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_word(make_dp(4'hE, 1'b1, OpMov, 1'b1, 4'd0, 4'd1, 12'h4FF));
        send_word(make_dp(4'hE, 1'b1, OpMov, 1'b1, 4'd0, 4'd2, 12'h000));
        send_word(make_dp(4'hE, 1'b0, OpAdd, 1'b1, 4'd14, 4'd3, 12'h00E));
        send_word(make_dp(4'hE, 1'b1, OpMov, 1'b1, 4'd0, 4'd4, 12'h020));
        send_word(make_dp(4'hE, 1'b0, OpMov, 1'b1, 4'd0, 4'd5, 12'h02E));
        send_word(make_dp(4'hE, 1'b0, OpMov, 1'b1, 4'd0, 4'd6, 12'h04E));
        send_word(make_dp(4'hE, 1'b0, OpMov, 1'b1, 4'd0, 4'd7, 12'h06E));
        send_word(make_dp(4'hE, 1'b0, OpMov, 1'b1, 4'd0, 4'd8, 12'h41E));
        send_word(make_dp(4'hE, 1'b0, OpMov, 1'b1, 4'd0, 4'd9, 12'h43E));
        send_word(make_dp(4'hE, 1'b0, OpMov, 1'b1, 4'd0, 4'd9, 12'h45E));
        send_word(make_dp(4'hE, 1'b0, OpMov, 1'b1, 4'd0, 4'd9, 12'h47E));
        send_word(make_dp(4'hF, 1'b1, OpMov, 1'b1, 4'd0, 4'd1, 12'h001));
        send_word(make_dp(4'h9, 1'b1, OpMov, 1'b0, 4'd0, 4'd1, 12'h001));
        send_word(make_dp(4'hE, 1'b1, OpMov, 1'b1, 4'd0, 4'd15, 12'h0FF));
        send_word(make_dp(4'hE, 1'b0, OpTst, 1'b0, 4'd14, 4'd0, 12'h000));
        send_word(32'hE12FFF1E);
        send_word(32'hE0000091);
        send_word(32'hEC000000);
        for (int op = 0; op < 16; op++)
            send_word(make_dp(4'hE, 1'b0, 4'(op), 1'b1, 4'd14, 4'd10, 12'h00E));
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 23 : (phase == 1) ? 51 : 0;
            recv_idle = (phase == 0) ? 51 : (phase == 1) ? 23 : 0;
            for (int i = 0; i < 460; i++) begin
                if (i % 100 == 0) load_values();
                send_word(random_word());
            end
            drain();
        end
        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
